>>> rtl/skf_pkg.sv
package skf_pkg;

  typedef logic signed [31:0] sample_t;
  typedef logic [31:0]        word_t;
  typedef logic [16:0]        gain_t;

  localparam int unsigned STEPS   = 17;
  localparam int unsigned CNT_W   = $clog2(STEPS);
  localparam int unsigned PADDR_W = 3;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);
  localparam gain_t ONE_Q16 = 17'h10000;

  localparam word_t PROCESS_NOISE_RST     = 32'd655;
  localparam word_t MEASUREMENT_NOISE_RST = 32'd32768;

  localparam logic REG_PROCESS_NOISE     = 1'b0;
  localparam logic REG_MEASUREMENT_NOISE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_WB   = 5'b10000
  } state_e;

endpackage

>>> rtl/skf_meas_if.sv
interface skf_meas_if;
  import skf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

>>> rtl/skf_res_if.sv
interface skf_res_if;
  import skf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t estimate;
  gain_t   gain;

  modport source (output valid, output estimate, output gain, input ready);
  modport sink (input valid, input estimate, input gain, output ready);
endinterface

>>> rtl/scalar_kalman_filter.sv
// Scalar Kalman filter (A = 1, H = 1, no control input).
// Measurements arrive on meas_i as signed Q16.16 items; each item yields one
// result item on res_o carrying the corrected estimate (signed Q16.16) and the
// gain used (unsigned Q1.16, 65536 meaning one).
// The process and measurement noise are written through the APB port at byte
// addresses 0 and 4; pready is always high and reads return the stored value.
// Between one acceptance and the next an item goes through these steps: the
// variance is predicted on acceptance, the divisor is formed, a radix-2
// restoring divider yields one gain bit per cycle, two shift-add multipliers
// consume one gain bit per cycle, and the new estimate and variance are
// committed. The result becomes valid with that commit.
// Only one item is in flight at a time; meas_i.ready is high while idle.
// A result waits in the output register while the receiver stalls, and the
// next item may be accepted meanwhile; its commit waits until the waiting
// result has been taken.
// Reset clears the estimate and the variance and loads the default noise
// values.
module scalar_kalman_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  skf_meas_if.sink                     meas_i,
  skf_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [skf_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import skf_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  word_t             pn_q, mn_q;
  word_t             est_q, var_q;

  word_t             pred_q, pred_d;
  logic [32:0]       div_q, div_d;
  logic [32:0]       rem_q, rem_d;
  logic [16:0]       quo_q, quo_d;
  logic [32:0]       diff_q, diff_d;
  logic [51:0]       emul_q, emul_d;
  logic [49:0]       vmul_q, vmul_d;
  gain_t             gain_q, gain_d;
  gain_t             gain_out_q, gain_out_d;

  logic [32:0]       pred_sum;
  word_t             pred_sat;
  logic [33:0]       div_trial;
  logic [33:0]       div_sub;
  logic              div_ge;
  gain_t             gain_new;
  logic [34:0]       emul_add;
  logic [33:0]       vmul_add;
  logic              commit;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MEASUREMENT_NOISE) ? mn_q : pn_q;

  assign meas_i.ready   = (state_q == S_IDLE);
  assign res_o.valid    = out_valid_q;
  assign res_o.estimate = est_q;
  assign res_o.gain     = gain_out_q;

  assign pred_sum  = {1'b0, var_q} + {1'b0, pn_q};
  assign pred_sat  = pred_sum[32] ? '1 : pred_sum[31:0];
  assign div_trial = {rem_q, (cnt_q == '0) ? pred_q[0] : 1'b0};
  assign div_sub   = div_trial - {1'b0, div_q};
  assign div_ge    = (div_trial >= {1'b0, div_q});
  assign gain_new  = (div_q == '0) ? '0 : {quo_q[15:0], div_ge};
  assign emul_add  = emul_q[0] ? (emul_q[51:17] + {{2{diff_q[32]}}, diff_q})
                               : emul_q[51:17];
  assign vmul_add  = vmul_q[0] ? ({1'b0, vmul_q[49:17]} + {2'b00, pred_q})
                               : {1'b0, vmul_q[49:17]};
  assign commit    = (state_q == S_WB) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    pred_d      = pred_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    diff_d      = diff_q;
    emul_d      = emul_q;
    vmul_d      = vmul_q;
    gain_d      = gain_q;
    gain_out_d  = gain_out_q;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (meas_i.valid) begin
          pred_d  = pred_sat;
          diff_d  = {meas_i.measurement[31], meas_i.measurement} - {est_q[31], est_q};
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        div_d   = {1'b0, pred_q} + {1'b0, mn_q};
        rem_d   = {2'b00, pred_q[31:1]};
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = div_ge ? div_sub[32:0] : div_trial[32:0];
        quo_d = {quo_q[15:0], div_ge};
        if (cnt_q == LAST_STEP) begin
          gain_d  = gain_new;
          emul_d  = {35'd0, gain_new};
          vmul_d  = {33'd0, ONE_Q16 - gain_new};
          cnt_d   = '0;
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MUL: begin
        emul_d = {emul_add[34], emul_add, emul_q[16:1]};
        vmul_d = {vmul_add, vmul_q[16:1]};
        if (cnt_q == LAST_STEP) begin
          state_d = S_WB;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_WB: begin
        if (commit) begin
          gain_out_d  = gain_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pn_q        <= PROCESS_NOISE_RST;
      mn_q        <= MEASUREMENT_NOISE_RST;
      est_q       <= '0;
      var_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr && (paddr[2] == REG_PROCESS_NOISE)) begin
        pn_q <= pwdata;
      end
      if (cfg_wr && (paddr[2] == REG_MEASUREMENT_NOISE)) begin
        mn_q <= pwdata;
      end
      if (commit) begin
        est_q <= est_q + emul_q[47:16];
        var_q <= vmul_q[47:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pred_q     <= pred_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    diff_q     <= diff_d;
    emul_q     <= emul_d;
    vmul_q     <= vmul_d;
    gain_q     <= gain_d;
    gain_out_q <= gain_out_d;
  end

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.gain <= ONE_Q16))
    else $error("gain above one");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_q != '0) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_wb_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && out_valid_q && !res_o.ready) |=> (state_q == S_WB))
    else $error("commit while a result item is still waiting");

  a_valid_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WB))
    else $error("result item raised outside write-back");

endmodule

>>> tb/tb_scalar_kalman_filter.sv
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 185;
  localparam int unsigned NUM_PHASES     = 9;

  localparam word_t PHASE_Q [NUM_PHASES] = '{
    32'd655, 32'h0000_0100, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000,
    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000
  };
  localparam word_t PHASE_R [NUM_PHASES] = '{
    32'd32768, 32'h0040_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000
  };

  typedef struct packed {
    sample_t estimate;
    gain_t   gain;
  } kf_result_t;

  class kalman_scoreboard;
    word_t        proc_noise;
    word_t        meas_noise;
    sample_t      estimate;
    word_t        variance;
    kf_result_t   pending[$];
    int unsigned  errors;
    int unsigned  print_cap;

    function new();
      proc_noise = PROCESS_NOISE_RST;
      meas_noise = MEASUREMENT_NOISE_RST;
      estimate   = '0;
      variance   = '0;
      errors     = 0;
      print_cap  = 100;
    endfunction

    function void report(string msg);
      if (errors < print_cap) begin
        $display("%0t: mismatch: %s", $time, msg);
      end
      errors++;
    endfunction

    function void set_reg(logic idx, word_t value);
      if (idx == REG_PROCESS_NOISE) begin
        proc_noise = value;
      end else begin
        meas_noise = value;
      end
    endfunction

    function word_t reg_value(logic idx);
      return (idx == REG_PROCESS_NOISE) ? proc_noise : meas_noise;
    endfunction

    // One filter step: predict, form the gain, correct and shrink the variance.
    function void note_meas(sample_t z);
      longint unsigned pred;
      longint unsigned divisor;
      longint unsigned gain_u;
      longint          diff;
      longint          corr;
      kf_result_t      res_item;
      pred = variance;
      pred += proc_noise;
      if (pred > 64'hFFFF_FFFF) begin
        pred = 64'hFFFF_FFFF;
      end
      divisor = pred + meas_noise;
      gain_u  = (divisor == 0) ? 64'd0 : (pred << 16) / divisor;
      diff     = longint'(z) - longint'(estimate);
      corr     = (longint'(gain_u) * diff) >>> 16;
      estimate = sample_t'(longint'(estimate) + corr);
      variance = word_t'(((64'd65536 - gain_u) * pred) >> 16);
      res_item.estimate = estimate;
      res_item.gain     = gain_t'(gain_u);
      pending.push_back(res_item);
    endfunction

    function void check_result(sample_t est_o, gain_t gain_o);
      kf_result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("result with none waiting: estimate %h gain %h", est_o, gain_o));
        return;
      end
      exp_r = pending.pop_front();
      if (est_o !== exp_r.estimate) begin
        report($sformatf("estimate %h, predicted %h", est_o, exp_r.estimate));
      end
      if (gain_o !== exp_r.gain) begin
        report($sformatf("gain %h, predicted %h", gain_o, exp_r.gain));
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  skf_meas_if meas ();
  skf_res_if  res ();

  kalman_scoreboard sb;
  int unsigned      snd_idle;
  int unsigned      rcv_idle;
  bit               hold_req;
  int unsigned      hold_left;
  int unsigned      idle_cycles;
  sample_t          level;

  scalar_kalman_filter dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .meas_i  (meas),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The receiver also honours a long hold-off so that the block fills up.
  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready) begin
      sb.check_result(res.estimate, res.gain);
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else begin
      res.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (meas.valid && meas.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_meas(sample_t z);
    while ($urandom_range(99) < snd_idle) begin
      meas.valid <= 1'b0;
      @(posedge clk);
    end
    meas.valid       <= 1'b1;
    meas.measurement <= z;
    @(posedge clk);
    while (!meas.ready) @(posedge clk);
    sb.note_meas(z);
  endtask

  task automatic drain();
    meas.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(logic idx, logic wr, word_t value, output word_t rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(logic idx);
    word_t rd;
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== sb.reg_value(idx)) begin
      sb.report($sformatf("register %0d reads %h, written %h", idx, rd, sb.reg_value(idx)));
    end
  endtask

  task automatic program_noise(word_t q, word_t r);
    word_t rd;
    apb_access(REG_PROCESS_NOISE, 1'b1, q, rd);
    sb.set_reg(REG_PROCESS_NOISE, q);
    check_reg(REG_PROCESS_NOISE);
    apb_access(REG_MEASUREMENT_NOISE, 1'b1, r, rd);
    sb.set_reg(REG_MEASUREMENT_NOISE, r);
    check_reg(REG_MEASUREMENT_NOISE);
  endtask

  // Mostly a noisy signal around a wandering level, with some wild samples.
  function automatic sample_t next_meas();
    int noise;
    noise = int'($urandom_range(262143)) - 131072;
    case ($urandom_range(9))
      0: return sample_t'($urandom());
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: begin
        if ($urandom_range(15) == 0) begin
          level = sample_t'($urandom()) >>> $urandom_range(16);
        end
        return sample_t'(level + noise);
      end
    endcase
  endfunction

  initial begin
    int unsigned p;
    int unsigned i;
    sb               = new();
    rst_n            = 1'b0;
    meas.valid       = 1'b0;
    meas.measurement = '0;
    res.ready        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    hold_req         = 1'b0;
    hold_left        = 0;
    idle_cycles      = 0;
    level            = '0;
    snd_idle         = 24;
    rcv_idle         = 54;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_reg(REG_PROCESS_NOISE);
    check_reg(REG_MEASUREMENT_NOISE);

    send_meas(32'sh0000_0000);
    send_meas(32'sh7FFF_FFFF);
    send_meas(32'sh8000_0000);
    send_meas(32'sh7FFF_FFFF);
    send_meas(32'sh0001_0000);
    send_meas(32'shFFFF_0000);
    send_meas(32'sh0000_0001);
    send_meas(32'shFFFF_FFFF);

    // With no noise at all the gain reaches one, then the divisor becomes zero.
    drain();
    program_noise(32'h0000_0000, 32'h0000_0000);
    send_meas(32'sh1234_5678);
    send_meas(-32'sd5);
    send_meas(32'sh8000_0000);

    // Huge process noise drives the predicted variance into saturation.
    drain();
    program_noise(32'hFFFF_FFFF, 32'h0000_0001);
    send_meas(32'sh8000_0000);
    send_meas(32'sh7FFF_FFFF);
    send_meas(32'sh8000_0000);

    drain();
    program_noise(32'h0000_0000, 32'hFFFF_FFFF);
    send_meas(32'sh7FFF_FFFF);
    send_meas(32'sh8000_0000);
    send_meas(32'sh0000_0000);

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin
          snd_idle = 24;
          rcv_idle = 54;
        end
        1: begin
          snd_idle = 54;
          rcv_idle = 24;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      drain();
      case (p)
        5: program_noise($urandom(), $urandom());
        8: program_noise($urandom_range(32'h0002_0000), $urandom());
        default: program_noise(PHASE_Q[p], PHASE_R[p]);
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 20) begin
          hold_req = 1'b1;
        end
        send_meas(next_meas());
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
